### hdl/tjfp_pkg.sv
// ----------------------------------------------------------------------------
// tjfp_pkg
// Shared constants, types and codes of the track jump false-positive filter.
// ----------------------------------------------------------------------------
package tjfp_pkg;

    localparam int TagSlots  = 1024;
    localparam int TagBits   = 10;
    localparam int CoordBits = 12;
    localparam int FracBits  = 8;
    localparam int DistBits  = 21;
    localparam int TurnBits  = 17;
    localparam int FrameBits = 32;
    localparam int HeadBits  = 16;
    // radicand width, kept even so the root takes whole bit pairs
    localparam int SqBits    = 2 * CoordBits + 2 + 2 * FracBits;
    localparam int RootBits  = (SqBits + 1) / 2;

    localparam logic [1:0] REG_JUMP_DIST  = 2'd0;
    localparam logic [1:0] REG_TURN_ANGLE = 2'd1;
    localparam logic [1:0] REG_TURN_DIST  = 2'd2;

    localparam logic [1:0] VERDICT_NORMAL   = 2'd0;
    localparam logic [1:0] VERDICT_FAR      = 2'd1;
    localparam logic [1:0] VERDICT_REPEAT   = 2'd2;
    localparam logic [1:0] VERDICT_SUSPECT  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_PREP,
        ST_MOD,
        ST_SQRT,
        ST_DIV_D,
        ST_DIV_T,
        ST_DECIDE,
        ST_OUT
    } state_t;

    // start and mode control of the shared divide/root unit
    typedef struct packed {
        logic start;
        logic is_sqrt;
    } unit_ctl_t;

endpackage

### hdl/track_jump_false_positive_filter.sv
// ----------------------------------------------------------------------------
// track_jump_false_positive_filter
// Per-tag detection filter flagging impossible or repeated jumps.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one detection per transaction; m_axis returns one verdict
//   per detection, in order. Limits are written through cfg_we/cfg_addr/
//   cfg_wdata while the block is idle.
// Sequencing:
//   One detection at a time; s_axis_tready is high only in the idle state.
//   For a detection after the first of its tag, the shared bit-serial unit
//   runs a 21-step square root and, for a frame gap above one, two 42-step
//   divisions. A heading difference of 360 degrees or more adds a pass
//   through the fold step.
// Reset:
//   aresetn (synchronous, low) restores the limits, then the per-tag status
//   store is cleared by a sweep over all 1024 tags, one tag per cycle, during
//   which s_axis_tready stays low.
// Stall:
//   A result waits in the output register until m_axis_tready; the next
//   detection is accepted only after it is taken.
// ----------------------------------------------------------------------------
module track_jump_false_positive_filter
    import tjfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tag_index[9:0], frame_number[41:10], x_pos[53:42], y_pos[65:54],
    // heading[81:66], zero pad to 88
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tag_out[9:0], mark_previous[10], verdict[12:11], step_distance[33:13],
    // zero pad to 40
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [11:0] cfg_wdata
);

    localparam int StoreBits = 1 + TurnBits + DistBits;  // seen, turn, dist
    localparam int HistBits  = FrameBits + 2 * CoordBits + HeadBits;
    // ceil(2^23 / 100): exact whole-degree quotient for any 16-bit difference
    localparam logic [16:0] DegRecip = 17'd83887;

    logic [11:0] jump_lim_reg;
    logic [7:0]  turn_lim_reg;
    logic [11:0] tdist_lim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jump_lim_reg  <= 12'd100;
            turn_lim_reg  <= 8'd90;
            tdist_lim_reg <= 12'd20;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_JUMP_DIST:  jump_lim_reg  <= cfg_wdata;
                REG_TURN_ANGLE: turn_lim_reg  <= cfg_wdata[7:0];
                REG_TURN_DIST:  tdist_lim_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // memories
    logic [StoreBits-1:0] stat_mem [TagSlots];
    logic [HistBits-1:0]  hist_mem [TagSlots];
    logic [StoreBits-1:0] stat_rd_reg;
    logic [HistBits-1:0]  hist_rd_reg;
    logic                 stat_we, hist_we;
    logic [TagBits-1:0]   wr_addr;
    logic [StoreBits-1:0] stat_wd;

    state_t state_reg, state_next;
    logic                 clr_reg;
    logic [TagBits:0]     clr_cnt_reg;

    // item registers
    logic [TagBits-1:0]   tag_reg;
    logic [FrameBits-1:0] frame_reg;
    logic [CoordBits-1:0] x_reg, y_reg;
    logic [HeadBits-1:0]  head_reg;
    logic [SqBits-1:0]    sq_reg, sq_next;
    logic [9:0]           deg_reg, deg_next;
    logic [FrameBits-1:0] gap_reg, gap_next;
    logic                 div_reg, div_next;
    logic [SqBits-1:0]    dist_reg, dist_next;
    logic [SqBits-1:0]    turn_reg, turn_next;
    logic                 valid_reg;
    logic [39:0]          out_reg;

    logic [TagBits-1:0]   s_tag;
    logic                 s_fire;
    logic                 tag_ok;

    assign s_tag  = s_axis_tdata[9:0];
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && !clr_reg;
    assign tag_ok = (32'(s_tag) < 32'(TagSlots));

    unit_ctl_t            u_ctl;
    logic [SqBits-1:0]    u_a;
    logic                 u_done;
    logic [SqBits-1:0]    u_res;

    tjfp_unit u_unit (
        .aclk(aclk), .aresetn(aresetn), .ctl(u_ctl), .op_a(u_a), .op_b(gap_reg),
        .done(u_done), .result(u_res)
    );

    // previous-state views
    logic                 seen;
    logic [TurnBits-1:0]  p_turn;
    logic [DistBits-1:0]  p_dist;
    logic [FrameBits-1:0] l_frame;
    logic [CoordBits-1:0] l_x, l_y;
    logic [HeadBits-1:0]  l_head;
    assign {seen, p_turn, p_dist} = stat_rd_reg;
    assign {l_frame, l_x, l_y, l_head} = hist_rd_reg;

    logic [CoordBits-1:0] dx, dy;
    logic [HeadBits-1:0]  dh;
    logic [32:0]          deg_prod;
    logic [FrameBits-1:0] fdiff;
    logic                 far, susp, rep, lt_far;
    logic [SqBits-1:0]    lim_far, lim_turn, lim_td, two;
    logic [SqBits-1:0]    adt, add_;
    logic                 fin;
    logic [1:0]           verd;
    logic                 mark;

    always_comb begin
        dx = (x_reg > l_x) ? x_reg - l_x : l_x - x_reg;
        dy = (y_reg > l_y) ? y_reg - l_y : l_y - y_reg;
        dh = (head_reg > l_head) ? head_reg - l_head : l_head - head_reg;
        deg_prod = 33'(dh) * 33'(DegRecip);
        fdiff = frame_reg - l_frame;
        lim_far  = SqBits'(jump_lim_reg) << FracBits;
        lim_turn = SqBits'(turn_lim_reg) << FracBits;
        lim_td   = SqBits'(tdist_lim_reg) << FracBits;
        two      = SqBits'(2) << FracBits;
        far    = dist_reg > lim_far;
        lt_far = dist_reg < lim_far;
        susp   = far || (turn_reg > lim_turn && dist_reg > lim_td);
        adt  = (SqBits'(p_turn) > turn_reg) ? SqBits'(p_turn) - turn_reg
                                            : turn_reg - SqBits'(p_turn);
        add_ = (SqBits'(p_dist) > dist_reg) ? SqBits'(p_dist) - dist_reg
                                            : dist_reg - SqBits'(p_dist);
        rep  = (adt < two) && (add_ < two) && !div_reg;
        verd = VERDICT_NORMAL;
        mark = 1'b0;
        if (susp) begin
            if (lt_far) begin
                verd = rep ? VERDICT_REPEAT : VERDICT_SUSPECT;
                mark = rep;
            end else begin
                verd = VERDICT_FAR;
                mark = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        sq_next   = sq_reg;
        deg_next  = deg_reg;
        gap_next  = gap_reg;
        div_next  = div_reg;
        dist_next = dist_reg;
        turn_next = turn_reg;
        u_ctl     = '0;
        u_a       = sq_reg;
        stat_we   = 1'b0;
        hist_we   = 1'b0;
        wr_addr   = tag_reg;
        stat_wd   = stat_rd_reg;
        fin       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) state_next = ST_READ;
            end
            ST_READ: begin
                // memory read registered at accept; clear the step for this item
                dist_next = '0;
                turn_next = '0;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                if (!seen) begin
                    // first sighting: store and report normal
                    stat_we = 1'b1;
                    stat_wd = {1'b1, p_turn, p_dist};
                    hist_we = 1'b1;
                    fin = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    sq_next = SqBits'((SqBits'(dx) * SqBits'(dx) + SqBits'(dy) * SqBits'(dy))
                              << (2 * FracBits));
                    deg_next = 10'(deg_prod >> 23);
                    gap_next = fdiff;
                    div_next = !fdiff[FrameBits-1] && (fdiff > 32'd1);
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                // fold the heading difference into 0..180
                if (deg_reg >= 10'd360) begin
                    deg_next = deg_reg - 10'd360;
                end else begin
                    if (deg_reg > 10'd180) deg_next = 10'd360 - deg_reg;
                    u_ctl.start = 1'b1;
                    u_ctl.is_sqrt = 1'b1;
                    u_a = sq_reg;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                turn_next = SqBits'(deg_reg) << FracBits;
                if (u_done) begin
                    dist_next = u_res;
                    if (div_reg) begin
                        u_ctl.start = 1'b1;
                        u_a = u_res;
                        state_next = ST_DIV_D;
                    end else begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DIV_D: begin
                if (u_done) begin
                    dist_next = u_res;
                    u_ctl.start = 1'b1;
                    u_a = turn_reg;
                    state_next = ST_DIV_T;
                end
            end
            ST_DIV_T: begin
                if (u_done) begin
                    turn_next = u_res;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                hist_we = 1'b1;
                if (susp && lt_far) begin
                    stat_we = 1'b1;
                    stat_wd = {1'b1, turn_reg[TurnBits-1:0], dist_reg[DistBits-1:0]};
                end
                fin = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!valid_reg || m_axis_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (clr_reg) begin
            stat_we = 1'b1;
            wr_addr = clr_cnt_reg[TagBits-1:0];
            stat_wd = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            valid_reg   <= 1'b0;
        end else begin
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (TagBits+1)'(TagSlots - 1)) clr_reg <= 1'b0;
            end
            // tags beyond the store skip straight to the result
            if (s_fire && !tag_ok) state_reg <= ST_OUT;
            else                   state_reg <= state_next;
            if (s_fire && !tag_ok) valid_reg <= 1'b1;
            else if (fin)          valid_reg <= 1'b1;
            else if (m_axis_tready) valid_reg <= 1'b0;
        end
        if (s_fire) begin
            tag_reg   <= s_tag;
            frame_reg <= s_axis_tdata[41:10];
            x_reg     <= s_axis_tdata[53:42];
            y_reg     <= s_axis_tdata[65:54];
            head_reg  <= s_axis_tdata[81:66];
            stat_rd_reg <= stat_mem[s_tag];
            hist_rd_reg <= hist_mem[s_tag];
        end
        if (s_fire && !tag_ok) begin
            out_reg <= {6'd0, 21'd0, VERDICT_NORMAL, 1'b0, s_tag};
        end else if (fin) begin
            out_reg <= {6'd0, dist_reg[DistBits-1:0], verd, mark, tag_reg};
        end
        if (stat_we) stat_mem[wr_addr] <= stat_wd;
        if (hist_we) hist_mem[tag_reg] <= {frame_reg, x_reg, y_reg, head_reg};
        sq_reg   <= sq_next;
        deg_reg  <= deg_next;
        gap_reg  <= gap_next;
        div_reg  <= div_next;
        dist_reg <= dist_next;
        turn_reg <= turn_next;
    end

    assign m_axis_tvalid = valid_reg && (state_reg == ST_OUT || state_reg == ST_IDLE);
    assign m_axis_tdata  = out_reg;

    a_ready_no_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !valid_reg) else $error("accepting while result pending");
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_reg |-> !s_axis_tready) else $error("accepting during clear");
    a_out_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && out_reg[12:11] == VERDICT_NORMAL |-> !out_reg[10])
        else $error("mark without verdict");

endmodule

### hdl/tjfp_unit.sv
// ----------------------------------------------------------------------------
// tjfp_unit
// Shared bit-serial unit: restoring division or integer square root,
// one result bit per cycle.
// ----------------------------------------------------------------------------
module tjfp_unit
    import tjfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  unit_ctl_t            ctl,
    input  logic [SqBits-1:0]    op_a,
    input  logic [FrameBits-1:0] op_b,
    output logic                 done,
    output logic [SqBits-1:0]    result
);

    localparam int CntBits = $clog2(SqBits + 1);
    localparam int RemBits = FrameBits + 2;

    logic               busy_reg, busy_next;
    logic               sqrt_reg, sqrt_next;
    logic [CntBits-1:0] cnt_reg, cnt_next;
    logic [SqBits-1:0]  num_reg, num_next;
    logic [SqBits-1:0]  quo_reg, quo_next;
    logic [RemBits-1:0] rem_reg, rem_next;
    logic [FrameBits-1:0] div_reg, div_next;
    logic               done_reg, done_next;

    logic [RemBits-1:0] shifted;
    logic [RemBits-1:0] trial;
    logic [RemBits:0]   diff;

    always_comb begin
        busy_next = busy_reg;
        sqrt_next = sqrt_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        shifted   = '0;
        trial     = '0;
        diff      = '0;
        if (ctl.start) begin
            busy_next = 1'b1;
            sqrt_next = ctl.is_sqrt;
            num_next  = op_a;
            div_next  = op_b;
            quo_next  = '0;
            rem_next  = '0;
            cnt_next  = ctl.is_sqrt ? CntBits'(RootBits) : CntBits'(SqBits);
        end else if (busy_reg) begin
            if (sqrt_reg) begin
                // bring down two radicand bits, try 4*root+1
                shifted = {rem_reg[RemBits-3:0], num_reg[SqBits-1 -: 2]};
                trial   = {quo_reg[RemBits-3:0], 2'b01};
                num_next = {num_reg[SqBits-3:0], 2'b00};
            end else begin
                shifted = {rem_reg[RemBits-2:0], num_reg[SqBits-1]};
                trial   = {2'b00, div_reg};
                num_next = {num_reg[SqBits-2:0], 1'b0};
            end
            diff = {1'b0, shifted} - {1'b0, trial};
            if (!diff[RemBits]) begin
                rem_next = diff[RemBits-1:0];
                quo_next = {quo_reg[SqBits-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[SqBits-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntBits'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        sqrt_reg <= sqrt_next;
        cnt_reg  <= cnt_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign done   = done_reg;
    assign result = quo_reg;

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("unit done while busy");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |=> busy_reg) else $error("unit not busy after start");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !ctl.start) else $error("unit restarted while busy");

endmodule
